// ----- hdl/mwxs_pkg.sv -----
`timescale 1ns / 1ps
// Package for the minimum-weight XOR subset search block.
// Holds sizing constants, shared types, the search state enum and helper functions.
// It has no dependencies.
package mwxs_pkg;

    localparam int MAX_MASKS  = 16;
    localparam int LIGHT_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam int PRESS_W    = 5;
    localparam int CNT_W      = $clog2(MAX_MASKS + 1);
    localparam int IDX_W      = (MAX_MASKS > 1) ? $clog2(MAX_MASKS) : 1;

    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [LIGHT_BITS-1:0] t_light;
    typedef logic [MAX_MASKS-1:0]  t_gray;
    typedef logic [PRESS_W-1:0]    t_press;

    typedef struct packed {
        logic               first_of_set;
        logic [FIELD_W-1:0] target_lights;
        logic [FIELD_W-1:0] toggle_mask;
        logic               last_of_set;
    } t_in_item;

    typedef struct packed {
        t_press min_presses;
        logic   found;
        logic   overflow;
    } t_out_item;

    typedef struct packed {
        logic   start;
        t_cnt   n;
        t_light target;
    } t_srch_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        t_cnt best;
        logic found;
    } t_srch_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN,
        S_OUT
    } t_srch_state;

    function automatic t_light to_light(input logic [FIELD_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[LIGHT_BITS-1:0];
    endfunction

    function automatic t_idx low_bit_index(input t_gray v);
        t_idx idx;
        idx = '0;
        for (int k = MAX_MASKS - 1; k >= 0; k--) begin
            if (v[k]) begin
                idx = t_idx'(k);
            end
        end
        return idx;
    endfunction

endpackage

// ----- hdl/mwxs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// It has no dependencies.
module mwxs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/mwxs_search.sv -----
`timescale 1ns / 1ps
// Subset search engine: walks the subsets in Gray-code order, one RAM read per step.
// Depends on mwxs_pkg; reads the mask RAM held by the top level.
module mwxs_search (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mwxs_pkg::t_srch_cmd  i_cmd,
    output mwxs_pkg::t_idx       o_raddr,
    input  mwxs_pkg::t_light     i_rdata,
    output mwxs_pkg::t_srch_stat o_stat
);

    mwxs_pkg::t_srch_state r_state, n_state;
    mwxs_pkg::t_gray       r_cnt;
    mwxs_pkg::t_gray       r_total;
    mwxs_pkg::t_gray       r_sel;
    mwxs_pkg::t_gray       total;
    mwxs_pkg::t_cnt        r_n;
    mwxs_pkg::t_cnt        r_weight;
    mwxs_pkg::t_cnt        r_best;
    mwxs_pkg::t_cnt        w_next;
    mwxs_pkg::t_light      r_target;
    mwxs_pkg::t_light      r_acc;
    mwxs_pkg::t_light      acc_next;
    mwxs_pkg::t_idx        r_pb;
    logic                  r_pvld;
    logic                  r_found;
    logic                  issue;
    logic                  begin_search;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwxs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        issue        = 1'b0;
        begin_search = 1'b0;
        unique case (r_state)
            mwxs_pkg::S_IDLE: begin
                if (i_cmd.start) begin
                    begin_search = 1'b1;
                    n_state      = mwxs_pkg::S_RUN;
                end
            end
            mwxs_pkg::S_RUN: begin
                issue = 1'b1;
                if (r_cnt == r_total) begin
                    n_state = mwxs_pkg::S_FIN;
                end
            end
            mwxs_pkg::S_FIN: begin
                n_state = mwxs_pkg::S_OUT;
            end
            mwxs_pkg::S_OUT: begin
                n_state = mwxs_pkg::S_IDLE;
            end
            default: begin
                n_state = mwxs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < mwxs_pkg::MAX_MASKS; k++) begin
            total[k] = (mwxs_pkg::t_cnt'(k) < i_cmd.n);
        end
    end

    assign o_raddr  = mwxs_pkg::low_bit_index(r_cnt);
    assign acc_next = r_acc ^ i_rdata;
    assign w_next   = r_sel[r_pb] ? (r_weight - mwxs_pkg::t_cnt'(1))
                                  : (r_weight + mwxs_pkg::t_cnt'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (begin_search) begin
            r_cnt    <= mwxs_pkg::t_gray'(1);
            r_total  <= total;
            r_n      <= i_cmd.n;
            r_target <= i_cmd.target;
            r_acc    <= '0;
            r_sel    <= '0;
            r_weight <= '0;
            r_best   <= i_cmd.n;
            r_found  <= 1'b0;
        end else begin
            if (issue) begin
                r_cnt <= r_cnt + mwxs_pkg::t_gray'(1);
                r_pb  <= o_raddr;
            end
            if (r_pvld) begin
                r_acc        <= acc_next;
                r_sel[r_pb]  <= ~r_sel[r_pb];
                r_weight     <= w_next;
                if (acc_next == r_target) begin
                    r_found <= 1'b1;
                    if (!r_found || (w_next < r_best)) begin
                        r_best <= w_next;
                    end
                end
            end
        end
    end

    assign o_stat.busy  = (r_state != mwxs_pkg::S_IDLE);
    assign o_stat.done  = (r_state == mwxs_pkg::S_OUT);
    assign o_stat.best  = r_best;
    assign o_stat.found = r_found;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> !o_stat.done)
        else $error("Result strobe lasted more than one cycle.");

    a_found_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.done && o_stat.found) |-> (r_best != '0))
        else $error("A match was reported for the empty subset.");

    a_best_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |-> (r_best <= r_n))
        else $error("Best subset size exceeds the mask count.");

    a_data_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pvld |-> ($past(r_state) == mwxs_pkg::S_RUN))
        else $error("RAM data consumed without a read issued.");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |-> (r_state == mwxs_pkg::S_IDLE))
        else $error("Search started while a search was running.");

endmodule

// ----- hdl/min_weight_xor_subset_search.sv -----
`timescale 1ns / 1ps
// An item without last_of_set is stored and yields no result.
// An item with last_of_set starts a search over 2^n - 1 subsets of the n stored masks,
// one mask RAM read per subset; o_done marks the result when the search ends.
// busy stays high through o_done, so no item is taken before the result; the receiver cannot stall.
// Synchronous active-low reset clears the mask count, target, overflow flag and search state.
module min_weight_xor_subset_search (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  mwxs_pkg::t_in_item  i_item,
    output logic                o_done,
    output mwxs_pkg::t_out_item o_result
);

    mwxs_pkg::t_cnt       r_count;
    mwxs_pkg::t_cnt       base_cnt;
    mwxs_pkg::t_light     r_target;
    mwxs_pkg::t_light     rd_data;
    mwxs_pkg::t_idx       rd_addr;
    mwxs_pkg::t_srch_cmd  cmd;
    mwxs_pkg::t_srch_stat stat;
    logic                 r_ovf;
    logic                 base_ovf;
    logic                 has_room;
    logic                 accept;

    assign accept   = start && !busy;
    assign base_cnt = i_item.first_of_set ? '0 : r_count;
    assign base_ovf = i_item.first_of_set ? 1'b0 : r_ovf;
    assign has_room = (base_cnt < mwxs_pkg::t_cnt'(mwxs_pkg::MAX_MASKS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_target <= '0;
        end else if (accept) begin
            r_count <= has_room ? (base_cnt + mwxs_pkg::t_cnt'(1)) : base_cnt;
            r_ovf   <= has_room ? base_ovf : 1'b1;
            if (i_item.first_of_set) begin
                r_target <= mwxs_pkg::to_light(i_item.target_lights);
            end
        end
    end

    mwxs_ram #(
        .WIDTH (mwxs_pkg::LIGHT_BITS),
        .DEPTH (mwxs_pkg::MAX_MASKS)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (accept && has_room),
        .i_waddr (base_cnt[mwxs_pkg::IDX_W-1:0]),
        .i_wdata (mwxs_pkg::to_light(i_item.toggle_mask)),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign cmd.start  = accept && i_item.last_of_set;
    assign cmd.n      = has_room ? (base_cnt + mwxs_pkg::t_cnt'(1)) : base_cnt;
    assign cmd.target = i_item.first_of_set ? mwxs_pkg::to_light(i_item.target_lights)
                                            : r_target;

    mwxs_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_raddr (rd_addr),
        .i_rdata (rd_data),
        .o_stat  (stat)
    );

    assign busy                 = stat.busy;
    assign o_done               = stat.done;
    assign o_result.min_presses = mwxs_pkg::t_press'(stat.best);
    assign o_result.found       = stat.found;
    assign o_result.overflow    = r_ovf;

endmodule
